@@ design/sfp_pkg.sv @@
`timescale 1ns / 1ps

package sfp_pkg;

  // Receiver phase
  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhLen  = 2'd1,
    PhSrc  = 2'd2,
    PhData = 2'd3
  } phase_e;

  // Result event codes
  typedef enum logic [2:0] {
    EvNone     = 3'd0,
    EvSensor   = 3'd1,
    EvSrc2     = 3'd2,
    EvOther    = 3'd3,
    EvBadStart = 3'd4,
    EvReject   = 3'd5
  } event_e;

  localparam logic [7:0] StartByte    = 8'hFF;
  localparam logic [7:0] SrcSensor    = 8'h01;
  localparam logic [7:0] SrcTwo       = 8'h02;
  localparam logic [7:0] MaxLenReset  = 8'd50;
  localparam int unsigned OutAxes     = 3;

endpackage

@@ design/sensor_frame_parser.sv @@
`timescale 1ns / 1ps

// Byte-serial frame receiver for a sensor link. Each input word is one
// received byte; each accepted byte produces exactly one result word in
// the next cycle, and a new byte is taken every cycle as long as the result
// register is empty or being drained in the same cycle. The whole per-byte
// step (phase update, payload store write, axis assembly) sits between the
// input handshake and the result register, so throughput is one byte per
// clock while results drain. A frame is a 0xFF start byte, a length
// byte (rejected when above max_frame_length), a source byte, then
// max(length-1,1) payload bytes. On the last payload byte of a source 1
// frame the first 2*SENSOR_AXES payload bytes are reported as signed
// little-endian axis values; bytes beyond that are counted but not kept,
// and a short frame reuses bytes left by earlier frames (zero after reset).
// max_frame_length must only be written while no result is outstanding.
module sensor_frame_parser
  import sfp_pkg::*;
#(
  parameter int unsigned SENSOR_AXES = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i,
  // byte input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         event_code_o,
  output logic signed [15:0] sensor_x_o,
  output logic signed [15:0] sensor_y_o,
  output logic signed [15:0] sensor_z_o,
  output logic [7:0]         payload_count_o
);

  localparam int unsigned StoreDepth = 2 * SENSOR_AXES;
  localparam int unsigned IdxW       = $clog2(StoreDepth);

  // Frame state
  phase_e      phase_q, phase_d;
  logic [7:0]  max_len_q;
  logic [7:0]  frame_len_q, frame_len_d;
  logic [7:0]  byte_pos_q, byte_pos_d;
  logic [7:0]  frame_src_q, frame_src_d;
  logic [7:0]  store_q [StoreDepth];
  logic [7:0]  store_d [StoreDepth];

  // Result register
  logic        out_valid_q;
  event_e      event_q, event_d;
  logic [15:0] axis_q [OutAxes];
  logic [15:0] axis_d [OutAxes];
  logic [7:0]  count_q, count_d;

  logic        accept;
  logic [7:0]  pos_inc;
  logic [7:0]  need;
  logic        frame_done;

  // Take a new word whenever the result slot is free or drains this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pos_inc    = byte_pos_q + 8'd1;
  // Length zero or one still takes one payload byte.
  assign need       = (frame_len_q > 8'd1) ? (frame_len_q - 8'd1) : 8'd1;
  assign frame_done = (pos_inc >= need);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PhHunt: begin
        if (rx_byte_i == StartByte) phase_d = PhLen;
      end
      PhLen: begin
        phase_d = (rx_byte_i > max_len_q) ? PhHunt : PhSrc;
      end
      PhSrc: begin
        phase_d = PhData;
      end
      PhData: begin
        if (frame_done) phase_d = PhHunt;
      end
      default: phase_d = PhHunt;
    endcase
  end

  // Frame registers, payload store and result event
  always_comb begin
    frame_len_d = frame_len_q;
    byte_pos_d  = byte_pos_q;
    frame_src_d = frame_src_q;
    store_d     = store_q;
    event_d     = EvNone;
    count_d     = 8'd0;
    case (phase_q)
      PhHunt: begin
        if (rx_byte_i != StartByte) event_d = EvBadStart;
      end
      PhLen: begin
        frame_len_d = rx_byte_i;
        byte_pos_d  = 8'd0;
        if (rx_byte_i > max_len_q) event_d = EvReject;
      end
      PhSrc: begin
        frame_src_d = rx_byte_i;
      end
      PhData: begin
        // Keep only the bytes that feed the axes; count the rest.
        if (byte_pos_q < 8'(StoreDepth)) store_d[byte_pos_q[IdxW-1:0]] = rx_byte_i;
        byte_pos_d = pos_inc;
        if (frame_done) begin
          count_d = pos_inc;
          if (frame_src_q == SrcSensor)   event_d = EvSensor;
          else if (frame_src_q == SrcTwo) event_d = EvSrc2;
          else                            event_d = EvOther;
        end
      end
      default: event_d = EvNone;
    endcase
  end

  // Assemble axis words from the store as it stands after this byte.
  for (genvar a = 0; a < OutAxes; a++) begin : g_axis
    if (a < SENSOR_AXES) begin : g_live
      assign axis_d[a] = (event_d == EvSensor) ? {store_d[2*a+1], store_d[2*a]} : 16'd0;
    end else begin : g_none
      assign axis_d[a] = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      max_len_q   <= MaxLenReset;
      frame_len_q <= 8'd0;
      byte_pos_q  <= 8'd0;
      frame_src_q <= 8'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < StoreDepth; i++) store_q[i] <= 8'd0;
    end else begin
      if (cfg_we_i) max_len_q <= cfg_data_i;
      if (accept) begin
        phase_q     <= phase_d;
        frame_len_q <= frame_len_d;
        byte_pos_q  <= byte_pos_d;
        frame_src_q <= frame_src_d;
        store_q     <= store_d;
      end
      // Hold the result until it is taken; refill in the same cycle.
      if (accept)           out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded on accept only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      event_q <= event_d;
      axis_q  <= axis_d;
      count_q <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_code_o    = event_q;
  assign sensor_x_o      = signed'(axis_q[0]);
  assign sensor_y_o      = signed'(axis_q[1]);
  assign sensor_z_o      = signed'(axis_q[2]);
  assign payload_count_o = count_q;

endmodule
